FILE: hdl/uita_pkg.sv
// Package for the unique ID table allocator.
// Holds the operation and status codes, the FSM state type and the command and status structs.
// No dependencies.
package uita_pkg;

   localparam int unsigned TableDepthDefault = 16;
   localparam logic [31:0] FirstIdReset      = 32'd100;

   // request operation codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_DEL   = 2'd1;
   localparam logic [1:0] FUNC_ALLOC = 2'd2;

   // response status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // response id source
   localparam logic [1:0] RID_IN   = 2'd0;
   localparam logic [1:0] RID_CAND = 2'd1;
   localparam logic [1:0] RID_ZERO = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       clear_step;
      logic       accept;
      logic       start_pass;
      logic       scan_step;
      logic       cand_inc;
      logic       write_new;
      logic       delete_hit;
      logic       set_result;
      logic [1:0] res_status;
      logic [1:0] res_id_sel;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       hit;
      logic       free_found;
      logic       scan_last;
      logic       out_free;
   } stat_type;

endpackage

FILE: hdl/uita_req_if.sv
// Request channel interface: valid/ready handshake with operation and identifier.
// No dependencies.
interface uita_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] id_in;

   modport source (output valid, output func, output id_in, input ready);
   modport sink   (input valid, input func, input id_in, output ready);
endinterface

FILE: hdl/uita_rsp_if.sv
// Response channel interface: valid/ready handshake with status and identifier.
// No dependencies.
interface uita_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] id_out;

   modport source (output valid, output status, output id_out, input ready);
   modport sink   (input valid, input status, input id_out, output ready);
endinterface

FILE: hdl/unique_id_table_allocator.sv
// Top level of the unique ID table allocator: controller plus datapath.
// Depends on uita_pkg, uita_req_if, uita_rsp_if, uita_controller, uita_datapath.
//
//   channel  | direction | handshake     | payload
//   req_if   | in        | valid / ready | func[1:0], id_in[31:0]
//   rsp_if   | out       | valid / ready | status[1:0], id_out[31:0]
//   csr_*    | in        | csr_we        | csr_wdata[31:0] -> first_id
//
// One transaction at a time. Add, delete and unused codes each make one full table scan
// (through the single memory read port). Allocate makes one full scan per candidate id,
// with from 1 to TABLE_DEPTH candidate ids scanned. After reset the table is cleared with
// req_if.ready low. A stalled response sits in the output register while the next
// request is taken; that request finishes once the register frees.
module unique_id_table_allocator
   import uita_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   uita_req_if.sink    req_if,
   uita_rsp_if.source  rsp_if,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   uita_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   uita_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_func   (req_if.func),
      .req_id_in  (req_if.id_in),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_status (rsp_if.status),
      .rsp_id_out (rsp_if.id_out)
   );

endmodule

FILE: hdl/uita_datapath.sv
// Datapath: ID table memory, scan counter, match/free tracking, candidate and response registers.
// Depends on uita_pkg.
module uita_datapath
   import uita_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_id_in,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_id_out
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // entry: {valid, id}
   logic [32:0]   mem [TABLE_DEPTH];
   logic [32:0]   mem_q_ff;

   logic [31:0]   first_id_ff;
   logic [1:0]    func_ff;
   logic [31:0]   id_ff;
   logic [31:0]   cand_ff;
   logic [AW-1:0] cnt_ff;
   logic          cmp_vld_ff;
   logic [AW-1:0] cmp_addr_ff;
   logic          hit_ff;
   logic [AW-1:0] hit_slot_ff;
   logic          free_ff;
   logic [AW-1:0] free_slot_ff;
   logic [1:0]    res_status_ff;
   logic [31:0]   res_id_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [31:0]   rsp_id_ff;

   logic [31:0]   key;
   logic          match;
   logic          empty;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [32:0]   mem_wdata;
   logic [AW-1:0] cnt_in;
   logic [31:0]   res_id_in;

   assign key   = (func_ff == FUNC_ALLOC) ? cand_ff : id_ff;
   assign match = cmp_vld_ff && mem_q_ff[32] && (mem_q_ff[31:0] == key);
   assign empty = cmp_vld_ff && !mem_q_ff[32];
   assign cnt_in = cnt_ff + 1'b1;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = 33'd0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.write_new) begin
         mem_we    = 1'b1;
         mem_waddr = free_slot_ff;
         mem_wdata = {1'b1, key};
      end else if (cmd.delete_hit) begin
         mem_we    = 1'b1;
         mem_waddr = hit_slot_ff;
         mem_wdata = {1'b0, id_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_step) begin
         mem_q_ff <= mem[cnt_ff];
      end
   end

   always_comb begin
      unique case (cmd.res_id_sel)
         RID_CAND: res_id_in = cand_ff;
         RID_ZERO: res_id_in = 32'd0;
         default:  res_id_in = id_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_id_ff  <= FirstIdReset;
         cnt_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            first_id_ff <= csr_wdata;
         end
         cmp_vld_ff <= cmd.scan_step;
         if (cmd.start_pass) begin
            cnt_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else begin
            if (cmd.clear_step || cmd.scan_step) begin
               cnt_ff <= cnt_in;
            end
            if (match) begin
               hit_ff <= 1'b1;
            end
            if (empty) begin
               free_ff <= 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         id_ff   <= req_id_in;
         cand_ff <= first_id_ff;
      end else if (cmd.cand_inc) begin
         cand_ff <= cand_ff + 32'd1;
      end
      cmp_addr_ff <= cnt_ff;
      if (match && !hit_ff) begin
         hit_slot_ff <= cmp_addr_ff;
      end
      if (empty && !free_ff) begin
         free_slot_ff <= cmp_addr_ff;
      end
      if (cmd.set_result) begin
         res_status_ff <= cmd.res_status;
         res_id_ff     <= res_id_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
      end
   end

   assign stat.func       = func_ff;
   assign stat.hit        = hit_ff;
   assign stat.free_found = free_ff;
   assign stat.scan_last  = (cnt_ff == AW'(TABLE_DEPTH - 1));
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_id_out = rsp_id_ff;

endmodule

FILE: hdl/uita_controller.sv
// Controller FSM: table clear after reset, scan passes, operation decision and response hand-off.
// Depends on uita_pkg.
module uita_controller
   import uita_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept     = 1'b1;
               cmd.start_pass = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.set_result = 1'b1;
            cmd.res_id_sel = RID_IN;
            cmd.res_status = ST_REFUSED;
            state_in       = S_RESP;
            unique case (stat.func)
               FUNC_ADD: begin
                  if (stat.hit) begin
                     cmd.res_status = ST_REFUSED;
                  end else if (!stat.free_found) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.write_new  = 1'b1;
                     cmd.res_status = ST_DONE;
                  end
               end
               FUNC_DEL: begin
                  if (stat.hit) begin
                     cmd.delete_hit = 1'b1;
                     cmd.res_status = ST_DONE;
                  end
               end
               FUNC_ALLOC: begin
                  if (!stat.free_found) begin
                     cmd.res_status = ST_FULL;
                     cmd.res_id_sel = RID_ZERO;
                  end else if (stat.hit) begin
                     // candidate taken, try the next one
                     cmd.set_result = 1'b0;
                     cmd.cand_inc   = 1'b1;
                     cmd.start_pass = 1'b1;
                     state_in       = S_SCAN;
                  end else begin
                     cmd.write_new  = 1'b1;
                     cmd.res_status = ST_DONE;
                     cmd.res_id_sel = RID_CAND;
                  end
               end
               default: begin
                  cmd.res_status = ST_REFUSED;
               end
            endcase
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/uita_checker.sv
// Port-level checks for the unique ID table allocator, bound to the top level.
// Depends on uita_pkg and unique_id_table_allocator.
module uita_checker
   import uita_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_id_out
);

   // one transaction in flight: ready drops right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted on two consecutive cycles");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_REFUSED ||
                     rsp_status == ST_FULL))
      else $error("undefined response status");

   // table clear and empty output after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!req_ready && !rsp_valid))
      else $error("block active right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_id_out)))
      else $error("stalled response changed");

endmodule

bind unique_id_table_allocator uita_checker u_uita_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_status (rsp_if.status),
   .rsp_id_out (rsp_if.id_out)
);
